/* sv/b2da_pkg.sv */
// Shared types and constants for the binary to decimal ASCII converter.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package b2da_pkg;

  // Digit index runs over the ten powers of ten, 10^9 first.
  localparam int unsigned IdxW = 4;
  localparam logic [IdxW-1:0] IDX_WIDE_START   = 4'd0;
  localparam logic [IdxW-1:0] IDX_NARROW_START = 4'd7;
  localparam logic [IdxW-1:0] IDX_LAST         = 4'd9;

  localparam logic [0:0] MODE_WIDE   = 1'b0;
  localparam logic [0:0] MODE_NARROW = 1'b1;

  localparam logic [5:0] ASCII_ZERO = 6'h30;

  // Input word: value and conversion mode.
  typedef struct packed {
    logic [31:0] value;
    logic        mode;
  } in_word_t;

  // Result word: one ASCII digit and the end-of-run flag.
  typedef struct packed {
    logic [5:0] digit_char;
    logic       last_digit;
  } out_word_t;

  // Classified job handed from the front to the back.
  typedef struct packed {
    logic [31:0]     value;
    logic [IdxW-1:0] start_idx;
  } job_t;

  // Back-end sequencer states.
  typedef enum logic {
    B_IDLE,
    B_COUNT
  } back_state_t;

  // Power of ten for a digit position.
  function automatic logic [31:0] pow10(input logic [IdxW-1:0] idx);
    logic [31:0] p;
    unique case (idx)
      4'd0:    p = 32'd1000000000;
      4'd1:    p = 32'd100000000;
      4'd2:    p = 32'd10000000;
      4'd3:    p = 32'd1000000;
      4'd4:    p = 32'd100000;
      4'd5:    p = 32'd10000;
      4'd6:    p = 32'd1000;
      4'd7:    p = 32'd100;
      4'd8:    p = 32'd10;
      4'd9:    p = 32'd1;
      default: p = 32'd1;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

/* sv/binary_to_decimal_ascii.sv */
// Top level of the binary to decimal ASCII converter.
// Instantiates b2da_front, b2da_queue and b2da_back; uses b2da_pkg.
//
//   Channel  Ports                        Word
//   input    in_valid, in_stall, in_word  value[31:0], mode
//   result   out_valid, out_stall, out_word  digit_char[5:0], last_digit
//
// Each digit is counted by repeated subtraction in the single subtractor of
// the back end, which first loads a job; a wide word gives ten digits, a
// narrow word three. Reset is synchronous and active low; it empties the
// front register, the queue and the output register. A stall on the result
// side holds the back end once it has a digit to emit; the front and the
// two-entry queue keep taking input words until they are full.
`default_nettype none

module binary_to_decimal_ascii (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire b2da_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output b2da_pkg::out_word_t      out_word
);
  import b2da_pkg::*;

  logic fq_valid, fq_ready;
  job_t fq_job;
  logic qb_valid, qb_pop;
  job_t qb_job;

  // Accept and classify.
  b2da_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job)
  );

  // Decouple front from back.
  b2da_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_job   (fq_job),
    .pop_valid  (qb_valid),
    .pop        (qb_pop),
    .pop_job    (qb_job)
  );

  // Convert and emit digits.
  b2da_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (qb_valid),
    .job_pop   (qb_pop),
    .job       (qb_job),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

/* sv/b2da_front.sv */
// Front end: accepts input words and classifies them into jobs.
// Depends on b2da_pkg.
`default_nettype none

module b2da_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire b2da_pkg::in_word_t in_word,
  output logic                    job_valid,
  input  wire logic               job_ready,
  output b2da_pkg::job_t          job
);
  import b2da_pkg::*;

  logic  valid_r, valid_nxt;
  job_t  job_r, job_nxt;
  logic  accept;

  // Hold a job until the queue takes it.
  assign in_stall  = valid_r & ~job_ready;
  assign accept    = in_valid & ~in_stall;
  assign job_valid = valid_r;
  assign job       = job_r;

  // Classify: narrow mode keeps only the low byte and starts at the hundreds.
  always_comb begin
    job_nxt   = job_r;
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
      if (in_word.mode == MODE_NARROW) begin
        job_nxt.value     = {24'd0, in_word.value[7:0]};
        job_nxt.start_idx = IDX_NARROW_START;
      end else begin
        job_nxt.value     = in_word.value;
        job_nxt.start_idx = IDX_WIDE_START;
      end
    end else if (job_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

endmodule

`default_nettype wire

/* sv/b2da_queue.sv */
// Two-entry job queue between the front and the back.
// Depends on b2da_pkg.
`default_nettype none

module b2da_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire b2da_pkg::job_t push_job,
  output logic                pop_valid,
  input  wire logic           pop,
  output b2da_pkg::job_t      pop_job
);
  import b2da_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop & pop_valid;

  // Storage for the queued jobs.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/b2da_back.sv */
// Back end: repeated-subtraction digit engine with a registered output word.
// Depends on b2da_pkg.
`default_nettype none

module b2da_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           job_valid,
  output logic                job_pop,
  input  wire b2da_pkg::job_t job,
  output logic                out_valid,
  input  wire logic           out_stall,
  output b2da_pkg::out_word_t out_word
);
  import b2da_pkg::*;

  back_state_t     state_r, state_nxt;
  logic [31:0]     rem_r, rem_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic [3:0]      cnt_r, cnt_nxt;
  logic            ovalid_r, ovalid_nxt;
  out_word_t       oword_r, oword_nxt;

  logic [31:0] step;
  logic        fits;
  logic        slot_free;
  logic        emit;

  assign step      = pow10(idx_r);
  assign fits      = (rem_r >= step);
  assign slot_free = ~ovalid_r | ~out_stall;
  assign emit      = (state_r == B_COUNT) & ~fits & slot_free;

  assign out_valid = ovalid_r;
  assign out_word  = oword_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (job_valid) begin
          state_nxt = B_COUNT;
        end
      end
      B_COUNT: begin
        if (emit && idx_r == IDX_LAST) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Datapath and outputs: one subtraction or, when the output slot is free, one digit per cycle.
  always_comb begin
    job_pop    = 1'b0;
    rem_nxt    = rem_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    oword_nxt  = oword_r;
    ovalid_nxt = ovalid_r & out_stall;
    unique case (state_r)
      B_IDLE: begin
        job_pop = job_valid;
        rem_nxt = job.value;
        idx_nxt = job.start_idx;
        cnt_nxt = 4'd0;
      end
      B_COUNT: begin
        if (fits) begin
          rem_nxt = rem_r - step;
          cnt_nxt = cnt_r + 4'd1;
        end else if (slot_free) begin
          oword_nxt.digit_char = ASCII_ZERO + {2'b00, cnt_r};
          oword_nxt.last_digit = (idx_r == IDX_LAST);
          ovalid_nxt           = 1'b1;
          idx_nxt              = idx_r + 4'd1;
          cnt_nxt              = 4'd0;
        end
      end
      default: begin
        job_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    idx_r   <= idx_nxt;
    cnt_r   <= cnt_nxt;
    oword_r <= oword_nxt;
  end

endmodule

`default_nettype wire
